FILE: rtl/core/float_switch_debounce_monitor_defines.svh
// Assertion macros for the float switch debounce monitor.
`ifndef FLOAT_SWITCH_DEBOUNCE_MONITOR_DEFINES_SVH
`define FLOAT_SWITCH_DEBOUNCE_MONITOR_DEFINES_SVH

`ifndef SYNTHESIS
`define FSDM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fsdm assertion failed");
`define FSDM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fsdm assertion failed");
`else
`define FSDM_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define FSDM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/fsdm_pkg.sv
// Shared types and constants of the float switch debounce monitor.
package fsdm_pkg;

   localparam int unsigned STABLE_W   = 16;
   localparam int unsigned UNSTABLE_W = 20;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned ADDR_W     = 3;
   localparam int unsigned DATA_W     = 32;

   localparam logic [STABLE_W-1:0]   STABLE_TIME_RESET   = 16'd1000;
   localparam logic [UNSTABLE_W-1:0] UNSTABLE_TIME_RESET = 20'd10000;
   localparam logic [TIME_W-1:0]     DEADLINE_RESET      = 32'd1000;

   typedef enum logic {
      REG_STABLE_TIME   = 1'b0,
      REG_UNSTABLE_TIME = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [STABLE_W-1:0]   stable_time_ms;
      logic [UNSTABLE_W-1:0] unstable_time_ms;
   } cfg_type;

   typedef struct packed {
      logic level_now;
      logic is_stable;
      logic is_full;
      logic is_reliable;
      logic status_changed;
      logic reliable_changed;
      logic warning_event;
      logic chatter_error;
   } result_type;

endpackage

FILE: rtl/core/float_switch_debounce_monitor.sv
// Top level: input register, debounce tracker and result register.
// A req_ sample passes the input register and then the result register before its result can leave on rsp_.
// Throughput: one sample per cycle unless a held result stalls the input register.
// A held result stalls the input register, whose stall then reaches req_stall.
// Reset: synchronous, active high; clears state and restores register defaults.
`include "float_switch_debounce_monitor_defines.svh"
module float_switch_debounce_monitor
   import fsdm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_switch_level,
   input  logic [TIME_W-1:0] req_now_ms,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_level_now,
   output logic              rsp_is_stable,
   output logic              rsp_is_full,
   output logic              rsp_is_reliable,
   output logic              rsp_status_changed,
   output logic              rsp_reliable_changed,
   output logic              rsp_warning_event,
   output logic              rsp_chatter_error,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type           cfg;
   result_type        result;
   result_type        result_ff;
   logic              in_valid_ff;
   logic              in_valid_in;
   logic              level_ff;
   logic [TIME_W-1:0] now_ff;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic              advance;
   logic              req_take;

   fsdm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   fsdm_track u_track (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .level  (level_ff),
      .now_ms (now_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         level_ff <= req_switch_level;
         now_ff   <= req_now_ms;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_level_now        = result_ff.level_now;
   assign rsp_is_stable        = result_ff.is_stable;
   assign rsp_is_full          = result_ff.is_full;
   assign rsp_is_reliable      = result_ff.is_reliable;
   assign rsp_status_changed   = result_ff.status_changed;
   assign rsp_reliable_changed = result_ff.reliable_changed;
   assign rsp_warning_event    = result_ff.warning_event;
   assign rsp_chatter_error    = result_ff.chatter_error;

   `FSDM_ASSERT_IMPLY(a_stall_needs_item, clock, reset, req_stall, in_valid_ff && out_valid_ff)
   `FSDM_ASSERT_NEXT(a_stage_drains, clock, reset, in_valid_ff && !rsp_stall, out_valid_ff)
   `FSDM_ASSERT_IMPLY(a_drop_by_chatter, clock, reset, out_valid_ff && rsp_reliable_changed, !rsp_is_reliable && rsp_chatter_error)
   `FSDM_ASSERT_IMPLY(a_warn_when_full, clock, reset, out_valid_ff && rsp_warning_event, rsp_is_full)
   `FSDM_ASSERT_IMPLY(a_change_unstable, clock, reset, out_valid_ff && rsp_status_changed, !rsp_is_stable)

endmodule

FILE: rtl/core/fsdm_csr.sv
// Configuration register file with APB-style access.
module fsdm_csr
   import fsdm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   logic [STABLE_W-1:0]   stable_time_ff;
   logic [STABLE_W-1:0]   stable_time_in;
   logic [UNSTABLE_W-1:0] unstable_time_ff;
   logic [UNSTABLE_W-1:0] unstable_time_in;
   logic                  write_en;
   reg_index_type         index;

   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign index      = reg_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   always_comb begin
      stable_time_in   = stable_time_ff;
      unstable_time_in = unstable_time_ff;
      if (write_en) begin
         unique case (index)
            REG_STABLE_TIME:   stable_time_in   = csr_pwdata[STABLE_W-1:0];
            REG_UNSTABLE_TIME: unstable_time_in = csr_pwdata[UNSTABLE_W-1:0];
            default:           stable_time_in   = stable_time_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_time_ff   <= STABLE_TIME_RESET;
         unstable_time_ff <= UNSTABLE_TIME_RESET;
      end else begin
         stable_time_ff   <= stable_time_in;
         unstable_time_ff <= unstable_time_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         unique case (index)
            REG_STABLE_TIME:
               csr_prdata = {{(DATA_W-STABLE_W){1'b0}}, stable_time_ff};
            REG_UNSTABLE_TIME:
               csr_prdata = {{(DATA_W-UNSTABLE_W){1'b0}}, unstable_time_ff};
            default:
               csr_prdata = '0;
         endcase
      end
   end

   assign cfg.stable_time_ms   = stable_time_ff;
   assign cfg.unstable_time_ms = unstable_time_ff;

endmodule

FILE: rtl/core/fsdm_track.sv
// Debounce state, chatter detection and warning latch for one sample per cycle while step is high.
module fsdm_track
   import fsdm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              level,
   input  logic [TIME_W-1:0] now_ms,
   input  cfg_type           cfg,
   output result_type        result
);

   logic              prev_level_ff,  prev_level_in;
   logic [TIME_W-1:0] deadline_ff,    deadline_in;
   logic [TIME_W-1:0] last_stable_ff, last_stable_in;
   logic              stable_ff,      stable_in;
   logic              warning_ff,     warning_in;
   logic              reliable_ff,    reliable_in;

   logic              changed;
   logic [TIME_W-1:0] since_deadline;
   logic [TIME_W-1:0] since_stable;
   logic              past_deadline;
   logic              unstable_expired;
   logic              full;
   logic              warn_fire;

   assign changed          = level != prev_level_ff;
   assign since_deadline   = now_ms - deadline_ff;
   assign since_stable     = now_ms - last_stable_ff;
   assign past_deadline    = (since_deadline != '0) && !since_deadline[TIME_W-1];
   assign unstable_expired =
      since_stable >= {{(TIME_W-UNSTABLE_W){1'b0}}, cfg.unstable_time_ms};

   always_comb begin
      prev_level_in  = prev_level_ff;
      deadline_in    = deadline_ff;
      last_stable_in = last_stable_ff;
      stable_in      = stable_ff;
      reliable_in    = reliable_ff;
      priority if (changed) begin
         prev_level_in = level;
         deadline_in   = now_ms + {{(TIME_W-STABLE_W){1'b0}}, cfg.stable_time_ms};
         stable_in     = 1'b0;
         if (unstable_expired) begin
            reliable_in = 1'b0;
         end
      end else if (past_deadline) begin
         stable_in      = 1'b1;
         last_stable_in = now_ms;
      end else begin
         stable_in      = stable_ff;
      end
   end

   assign full      = (stable_in && level) || !reliable_in;
   assign warn_fire = full && !warning_ff;

   always_comb begin
      warning_in = warning_ff || warn_fire;
      if (stable_in && !level) begin
         warning_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff  <= 1'b0;
         deadline_ff    <= DEADLINE_RESET;
         last_stable_ff <= '0;
         stable_ff      <= 1'b0;
         warning_ff     <= 1'b0;
         reliable_ff    <= 1'b1;
      end else if (step) begin
         prev_level_ff  <= prev_level_in;
         deadline_ff    <= deadline_in;
         last_stable_ff <= last_stable_in;
         stable_ff      <= stable_in;
         warning_ff     <= warning_in;
         reliable_ff    <= reliable_in;
      end
   end

   assign result.level_now        = level;
   assign result.is_stable        = stable_in;
   assign result.is_full          = full;
   assign result.is_reliable      = reliable_in;
   assign result.status_changed   = changed;
   assign result.reliable_changed = reliable_ff && !reliable_in;
   assign result.warning_event    = warn_fire;
   assign result.chatter_error    = changed && unstable_expired;

endmodule

FILE: dv/float_switch_debounce_monitor_test.sv
// Self-checking testbench for the float switch debounce monitor: directed and random samples.
`timescale 1ns / 1ps

module float_switch_debounce_monitor_test;
   import fsdm_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 4;

   logic              clock;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic              req_switch_level = 1'b0;
   logic [TIME_W-1:0] req_now_ms       = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic              rsp_level_now;
   logic              rsp_is_stable;
   logic              rsp_is_full;
   logic              rsp_is_reliable;
   logic              rsp_status_changed;
   logic              rsp_reliable_changed;
   logic              rsp_warning_event;
   logic              rsp_chatter_error;
   logic              csr_psel         = 1'b0;
   logic              csr_penable      = 1'b0;
   logic              csr_pwrite       = 1'b0;
   logic [ADDR_W-1:0] csr_paddr        = '0;
   logic [DATA_W-1:0] csr_pwdata       = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   float_switch_debounce_monitor DUT (.*);

   // debounce tracker state and settings, as the block should hold them
   logic [STABLE_W-1:0]   stable_hold_ms    = STABLE_TIME_RESET;
   logic [UNSTABLE_W-1:0] chatter_window_ms = UNSTABLE_TIME_RESET;
   logic                  prior_level       = 1'b0;
   logic [TIME_W-1:0]     deadline_ms       = DEADLINE_RESET;
   logic [TIME_W-1:0]     last_stable_ms    = '0;
   logic                  stable_seen       = 1'b0;
   logic                  warn_latched      = 1'b0;
   logic                  reliable_now      = 1'b1;

   result_type        awaited_status[$];
   logic [TIME_W-1:0] sample_time = '0;
   int                idle_pct    = 0;
   int                stall_pct   = 0;
   int                mismatches  = 0;
   int                quiet_cycles = 0;
   string             field_name[8] = '{"chatter_error", "warning_event", "reliable_changed",
                                        "status_changed", "is_reliable", "is_full",
                                        "is_stable", "level_now"};

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic result_type debounce_sample(input logic lvl, input logic [TIME_W-1:0] now);
      result_type        r;
      logic [TIME_W-1:0] since_deadline;
      logic [TIME_W-1:0] since_stable;
      r = '0;
      since_deadline = now - deadline_ms;
      since_stable   = now - last_stable_ms;
      if (lvl != prior_level) begin
         r.status_changed = 1'b1;
         prior_level      = lvl;
         deadline_ms      = now + TIME_W'(stable_hold_ms);
         stable_seen      = 1'b0;
         if (since_stable >= TIME_W'(chatter_window_ms)) begin
            r.chatter_error    = 1'b1;
            r.reliable_changed = reliable_now;
            reliable_now       = 1'b0;
         end
      end else if ($signed(since_deadline) > 0) begin
         stable_seen    = 1'b1;
         last_stable_ms = now;
      end
      r.is_full = (stable_seen && lvl) || !reliable_now;
      if (r.is_full && !warn_latched) begin
         r.warning_event = 1'b1;
         warn_latched    = 1'b1;
      end
      if (stable_seen && !lvl) warn_latched = 1'b0;
      r.level_now   = lvl;
      r.is_stable   = stable_seen;
      r.is_reliable = reliable_now;
      return r;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatches++;
      $display("%0t ns: %s", $time, what);
   endtask

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin : check_results
      result_type seen;
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_level_now, rsp_is_stable, rsp_is_full, rsp_is_reliable,
                 rsp_status_changed, rsp_reliable_changed, rsp_warning_event,
                 rsp_chatter_error};
         if (awaited_status.size() == 0) begin
            flag_mismatch("result transfer with none outstanding");
         end else begin
            want = awaited_status.pop_front();
            for (int i = 0; i < 8; i++) begin
               if (seen[i] !== want[i])
                  flag_mismatch($sformatf("%s is %b, want %b", field_name[i], seen[i], want[i]));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("float_switch_debounce_monitor verification failed");
         $finish;
      end
   end

   task automatic send_sample(input logic lvl, input logic [TIME_W-1:0] now);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_switch_level <= lvl;
      req_now_ms       <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      awaited_status.push_back(debounce_sample(lvl, now));
      sample_time = now;
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (awaited_status.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_register(input reg_index_type idx);
      logic [DATA_W-1:0] want;
      want = (idx == REG_STABLE_TIME) ? DATA_W'(stable_hold_ms) : DATA_W'(chatter_window_ms);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_W'({idx, 2'b00});
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== want)
         flag_mismatch($sformatf("%s reads %0d, want %0d", idx.name(), csr_prdata, want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_register(input reg_index_type idx, input logic [DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_STABLE_TIME: begin
            stable_hold_ms = value[STABLE_W-1:0];
         end
         REG_UNSTABLE_TIME: begin
            chatter_window_ms = value[UNSTABLE_W-1:0];
         end
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      check_register(idx);
   endtask

   task automatic test_reset_values();
      check_register(REG_STABLE_TIME);
      check_register(REG_UNSTABLE_TIME);
   endtask

   task automatic test_debounce_edges();
      send_sample(1'b0, 32'd0);
      send_sample(1'b0, 32'd1000);
      send_sample(1'b0, 32'd1001);
      send_sample(1'b1, 32'd1500);
      send_sample(1'b1, 32'd2500);
      send_sample(1'b1, 32'd2501);
      send_sample(1'b1, 32'd3000);
      send_sample(1'b0, 32'd3100);
      send_sample(1'b0, 32'd4101);
      // walk time up to the wrap, settling before every level change
      while ((32'hFFFF_FD00 - deadline_ms) > 32'h7000_0000) begin
         send_sample(prior_level, deadline_ms + 32'h7000_0000);
         send_sample(!prior_level, sample_time + 32'd1);
      end
      send_sample(prior_level, 32'hFFFF_FD00);
      send_sample(!prior_level, 32'hFFFF_FE00);
      send_sample(prior_level, 32'hFFFF_FFFF);
      send_sample(prior_level, deadline_ms);
      send_sample(prior_level, deadline_ms + 32'd1);
   endtask

   task automatic run_sample_phase(input int idle, input int stall,
                                   input logic [DATA_W-1:0] hold_raw,
                                   input logic [DATA_W-1:0] window_raw,
                                   input int count, input int noise_pct);
      logic              lvl;
      logic [TIME_W-1:0] now;
      int                pick;
      settle_block();
      program_register(REG_STABLE_TIME, hold_raw);
      program_register(REG_UNSTABLE_TIME, window_raw);
      idle_pct  = idle;
      stall_pct = stall;
      now = sample_time;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         lvl  = prior_level;
         if (pick < noise_pct) begin
            lvl = 1'($urandom_range(1));
            now = $urandom();
         end else if (pick < 30) begin
            lvl = !prior_level;
            now += $urandom_range(0, stable_hold_ms / 2 + 1);
         end else if (pick < 40 && !stable_seen) begin
            now = deadline_ms + $urandom_range(1);
         end else if (pick < 45) begin
            lvl = 1'($urandom_range(1));
         end else begin
            now += $urandom_range(0, 2 * stable_hold_ms + 2);
         end
         send_sample(lvl, now);
      end
   endtask

   task automatic test_chatter_latch();
      settle_block();
      program_register(REG_STABLE_TIME, 32'd100);
      program_register(REG_UNSTABLE_TIME, 32'd500);
      idle_pct  = 0;
      stall_pct = 0;
      send_sample(prior_level, ($signed(deadline_ms - sample_time) > 0) ?
                  deadline_ms + 32'd1 : sample_time + 32'd1);
      send_sample(!prior_level, last_stable_ms + 32'd499);
      send_sample(prior_level, deadline_ms + 32'd1);
      send_sample(!prior_level, last_stable_ms + 32'd500);
      send_sample(!prior_level, sample_time + 32'd1);
      if (prior_level) send_sample(1'b0, sample_time + 32'd1);
      send_sample(1'b0, deadline_ms + 32'd1);
      send_sample(1'b0, deadline_ms + 32'd7);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_debounce_edges();
      run_sample_phase(0, 0, 32'hA5A5_0000, 32'hFFFF_FFFF, 300, 0);
      run_sample_phase(79, 0, 32'hFFFF_FFFF, 32'h0FFF_FFFF, 300, 0);
      run_sample_phase(0, 79, {16'($urandom()), 16'($urandom_range(1, 5000))},
                       32'h000F_FFFF, 300, 0);
      test_chatter_latch();
      run_sample_phase(9, 9, {16'($urandom()), 16'($urandom_range(0, 300))},
                       32'hABC0_0000, 600, 10);
      settle_block();
      if (mismatches == 0) begin
         $display("float_switch_debounce_monitor verification clean");
      end else begin
         $display("float_switch_debounce_monitor verification failed");
      end
      $finish;
   end

endmodule
